// ----- sv/dq_pkg.sv -----
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DqDepth = 16;
  localparam int KeyW    = 32;
  localparam int OccW    = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_POP_FRONT  = 2'd1,
    REQ_PUSH_BACK  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    req_e                    req_type;
    logic signed [KeyW-1:0]  key_in;
  } in_t;

  typedef struct packed {
    logic signed [KeyW-1:0]  key_out;
    status_e                 status;
    logic        [OccW-1:0]  occupancy;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- sv/double_ended_queue.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (req_type, key_in)
// out      output     out_valid_o / out_stall_i  out_data_o (key_out, status, occupancy)
//
// Each request has two steps: capture takes it and reads the slot store, whose read
// data is registered; execute updates the indices and loads the result.
// The result sits in an output register, so a new request is taken while it waits.
// When out_stall_i holds a result, a second request waits in execute until it clears.
// Reset clears the front index, the occupancy and the output valid flag; slot contents
// stay undefined until pushed.

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DqDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  dq_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output dq_pkg::out_t out_data_o
);
  import dq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/dq_ctrl.sv -----
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dq_pkg::sts_t sts_i,
  output dq_pkg::cmd_t cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_EXEC))
    else $error("captured request did not move the controller to execute");

  a_no_capture_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (!cmd_o.capture && in_stall_o))
    else $error("request captured while another is in flight");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit issued while output register is occupied");

endmodule

// ----- sv/dq_dpath.sv -----
`timescale 1ns / 1ps

module dq_dpath #(
  parameter int DEPTH = dq_pkg::DqDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dq_pkg::cmd_t cmd_i,
  output dq_pkg::sts_t sts_o,
  input  dq_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output dq_pkg::out_t out_data_o
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [KeyW-1:0] mem [DEPTH];

  logic [AW-1:0]          front_q, front_d;
  logic [CW-1:0]          count_q, count_d;
  req_e                   req_q;
  logic signed [KeyW-1:0] key_q;
  logic signed [KeyW-1:0] rdata_q;
  logic                   out_valid_q;
  out_t                   out_q, out_d;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail_idx, back_idx, front_dec, front_inc, rd_addr, wr_addr;
  logic          empty, full, wr_en;

  // Slot after the back key; front + count stays below twice the depth.
  assign tail_sum = (CW+1)'(front_q) + (CW+1)'(count_q);
  assign tail_idx = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign back_idx  = (tail_idx == '0) ? AW'(DEPTH - 1) : tail_idx - 1'b1;
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));

  assign rd_addr = (in_data_i.req_type == REQ_POP_FRONT) ? front_q : back_idx;
  assign wr_addr = (req_q == REQ_PUSH_FRONT) ? front_dec : tail_idx;

  always_comb begin
    front_d           = front_q;
    count_d           = count_q;
    wr_en             = 1'b0;
    out_d.key_out     = '0;
    out_d.status      = ST_OK;
    case (req_q)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          out_d.status = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (req_q == REQ_PUSH_FRONT) begin
            front_d = front_dec;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.key_out = rdata_q;
          count_d       = count_q - 1'b1;
          if (req_q == REQ_POP_FRONT) begin
            front_d = front_inc;
          end
        end
      end
      default: begin
        out_d.status = ST_OK;
      end
    endcase
    out_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= mem[rd_addr];
      req_q   <= in_data_i.req_type;
      key_q   <= in_data_i.key_in;
    end
    if (cmd_i.commit && wr_en) begin
      mem[wr_addr] <= key_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        front_q     <= front_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy exceeds queue depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= AW'(DEPTH - 1))
    else $error("front index outside the store");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed request produced no result");

  a_refused_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !wr_en && !(out_d.status == ST_OK)) |=>
      (count_q == $past(count_q) && front_q == $past(front_q)))
    else $error("refused request changed the queue");

endmodule
